>>> sv/difficulty_retarget_unit_macros.svh
// Assertion macros shared by the difficulty retarget RTL.
`ifndef DIFFICULTY_RETARGET_UNIT_MACROS_SVH
`define DIFFICULTY_RETARGET_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define DRU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DRU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DRU_ASSERT_IMP(label, ante, cons)
`define DRU_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> sv/dret_pkg.sv
// Package with constants, types and helper functions of the difficulty retarget unit.
`default_nettype none
package dret_pkg;

	localparam int unsigned TS_W     = 40;
	localparam int unsigned BITS_W   = 32;
	localparam int unsigned EL_W     = 64;
	localparam int unsigned MULT_W   = 42;
	localparam int unsigned PROD_W   = 66;
	localparam int unsigned DIV_W    = 314;
	localparam int unsigned TGT_W    = 256;

	localparam logic [TS_W-1:0]   TIMESPAN_RESET = 40'd1209600;
	localparam logic [BITS_W-1:0] LIMIT_RESET    = 32'h1e0fffff;

	typedef enum logic {
		REG_TIMESPAN = 1'b0,
		REG_LIMIT    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] mant;
		logic [4:0]  off;
	} cmpt_t;

	// Splits a compact word into the mantissa that survives and its byte offset.
	function automatic cmpt_t expand_bits(input logic [BITS_W-1:0] b);
		logic [7:0]  e;
		logic [23:0] m;
		logic [7:0]  off;
		cmpt_t       r;
		e = b[31:24];
		m = b[23:0];
		off = e - 8'd3;
		r.mant = '0;
		r.off = '0;
		if (e <= 8'd3) begin
			r.mant = m >> {(2'd3 - e[1:0]), 3'b000};
		end else if (off < 8'd32) begin
			r.off = off[4:0];
			case (off[4:0])
				5'd31: begin
					r.mant = {16'h0000, m[7:0]};
				end
				5'd30: begin
					r.mant = {8'h00, m[15:0]};
				end
				default: begin
					r.mant = m;
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [TGT_W-1:0] widen(input cmpt_t c);
		return TGT_W'(c.mant) << {c.off, 3'b000};
	endfunction

endpackage
`default_nettype wire

>>> sv/difficulty_retarget_unit.sv
// Top level of the difficulty retarget unit: clamp, scale, long division, cap and encode.
// Usage:
// The item channel (item_valid/item_ready) carries an old compact target word
// and a signed elapsed time; the result channel (result_valid/result_ready)
// returns the new compact target, one result transaction per item transaction.
// Two registers sit on the APB-style port: the target timespan at byte address
// 0 and the limit in compact form at byte address 8. Write them only while no
// transaction is in flight.
// The datapath is a pipeline of 321 register stages: clamp, multiply, align,
// one restoring division step per stage over the 314-bit dividend, then cap,
// byte flags, size search and encode. A new transaction may enter in every
// cycle while the receiver does not stall, so throughput is one per cycle.
// The depth is set by the bit-per-stage divider.
// Reset clears all valid bits and loads the register defaults (timespan
// 1209600, limit 0x1e0fffff). When the receiver stalls, the whole pipeline
// holds: item_ready falls in the same cycle and nothing is lost or repeated.
`default_nettype none
`include "difficulty_retarget_unit_macros.svh"
module difficulty_retarget_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [31:0] old_bits,
	input  wire logic [63:0] elapsed_time,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [31:0]      new_bits,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int unsigned DW = dret_pkg::DIV_W;

	// Configuration registers.
	logic [dret_pkg::TS_W-1:0]   timespan_q;
	logic [dret_pkg::BITS_W-1:0] limit_q;
	logic [dret_pkg::TGT_W-1:0]  lim_wide_q;
	logic [dret_pkg::TS_W-1:0]   ts_eff;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign ts_eff = (timespan_q == '0) ? dret_pkg::TS_W'(1) : timespan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timespan_q <= dret_pkg::TIMESPAN_RESET;
			limit_q <= dret_pkg::LIMIT_RESET;
		end else if (cfg_wr) begin
			case (dret_pkg::reg_idx_t'(paddr[3]))
				dret_pkg::REG_TIMESPAN: begin
					timespan_q <= pwdata[39:0];
				end
				dret_pkg::REG_LIMIT: begin
					limit_q <= pwdata[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The expanded limit is only needed at the cap stage, after the division stages.
	always_ff @(posedge clk) begin
		lim_wide_q <= dret_pkg::widen(dret_pkg::expand_bits(limit_q));
	end

	always_comb begin
		case (dret_pkg::reg_idx_t'(paddr[3]))
			dret_pkg::REG_TIMESPAN: prdata = {24'h000000, timespan_q};
			dret_pkg::REG_LIMIT:    prdata = {32'h00000000, limit_q};
			default:                prdata = '0;
		endcase
	end

	// A single enable moves every stage; the last stage is the output register.
	logic en;
	assign en = !result_valid || result_ready;
	assign item_ready = en;

	// Stage 1: clamp the elapsed time and expand the old target.
	logic                          v_s1;
	logic [dret_pkg::MULT_W-1:0]   m_s1;
	logic [23:0]                   mant_s1;
	logic [4:0]                    off_s1;
	logic signed [63:0]            lo_c;
	logic signed [63:0]            hi_c;
	logic signed [63:0]            el_c;
	logic [63:0]                   clamp_c;
	dret_pkg::cmpt_t               old_c;

	always_comb begin
		lo_c = $signed({26'h0, ts_eff[39:2]});
		hi_c = $signed({22'h0, ts_eff, 2'b00});
		el_c = $signed(elapsed_time);
		clamp_c = elapsed_time;
		if (el_c < lo_c) begin
			clamp_c = lo_c;
		end
		if (el_c > hi_c) begin
			clamp_c = hi_c;
		end
		old_c = dret_pkg::expand_bits(old_bits);
	end

	// Stage 2: two partial products of the mantissa and the clamped time.
	logic        v_s2;
	logic [44:0] pl_s2;
	logic [44:0] ph_s2;
	logic [4:0]  off_s2;

	// Stage 3: full product aligned to its byte offset, the dividend.
	logic          v_s3;
	logic [DW-1:0] d_s3;
	logic [66:0]   prod_c;

	assign prod_c = 67'(pl_s2) + (67'(ph_s2) << 21);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= clamp_c[dret_pkg::MULT_W-1:0];
			mant_s1 <= old_c.mant;
			off_s1 <= old_c.off;
			pl_s2 <= 45'(mant_s1) * 45'(m_s1[20:0]);
			ph_s2 <= 45'(mant_s1) * 45'(m_s1[41:21]);
			off_s2 <= off_s1;
			d_s3 <= DW'(prod_c[dret_pkg::PROD_W-1:0]) << {off_s2, 3'b000};
		end
	end

	// Stage 4: restoring division, one quotient bit per step. The word shifts
	// left; dividend bits leave at the top and quotient bits enter at the bottom.
	logic                      v_s4   [DW];
	logic [DW-1:0]             w_s4   [DW];
	logic [dret_pkg::TS_W-1:0] rem_s4 [DW];

	for (genvar i = 0; i < DW; i++) begin : g_div
		logic [DW-1:0]             w_in;
		logic [dret_pkg::TS_W-1:0] r_in;
		logic [dret_pkg::TS_W:0]   trial;
		logic                      ge;

		if (i == 0) begin : g_first
			assign w_in = d_s3;
			assign r_in = '0;
		end else begin : g_next
			assign w_in = w_s4[i-1];
			assign r_in = rem_s4[i-1];
		end

		assign trial = {r_in, w_in[DW-1]};
		assign ge = trial >= {1'b0, ts_eff};

		always_ff @(posedge clk) begin
			if (en) begin
				w_s4[i] <= {w_in[DW-2:0], ge};
				rem_s4[i] <= ge ? dret_pkg::TS_W'(trial - {1'b0, ts_eff}) : trial[39:0];
			end
		end
	end

	// Stage 5: keep the quotient modulo 2^256 and cap it at the limit.
	logic                       v_s5;
	logic [dret_pkg::TGT_W-1:0] nt_s5;
	logic [dret_pkg::TGT_W-1:0] q_c;

	assign q_c = w_s4[DW-1][dret_pkg::TGT_W-1:0];

	// Stage 6: one flag per non-zero byte.
	logic                       v_s6;
	logic [dret_pkg::TGT_W-1:0] nt_s6;
	logic [31:0]                nz_s6;
	logic [31:0]                nz_c;

	always_comb begin
		for (int b = 0; b < 32; b++) begin
			nz_c[b] = |nt_s5[8*b +: 8];
		end
	end

	// Stage 7: significant byte count.
	logic                       v_s7;
	logic [dret_pkg::TGT_W-1:0] nt_s7;
	logic [5:0]                 sz_s7;
	logic [5:0]                 sz_c;

	always_comb begin
		sz_c = '0;
		for (int b = 0; b < 32; b++) begin
			if (nz_s6[b]) begin
				sz_c = 6'(b + 1);
			end
		end
	end

	// Stage 8: pick the three top bytes, normalise the mantissa sign bit.
	logic        v_s8;
	logic [31:0] bits_s8;
	logic [dret_pkg::TGT_W+15:0] pad_c;
	logic [4:0]  szm1_c;
	logic [23:0] mant_c;
	logic [7:0]  exp_c;

	always_comb begin
		pad_c = {nt_s7, 16'h0000};
		szm1_c = 5'(sz_s7 - 6'd1);
		mant_c = '0;
		if (sz_s7 != '0) begin
			mant_c = pad_c[{szm1_c, 3'b000} +: 24];
		end
		exp_c = {2'b00, sz_s7};
		if (mant_c[23]) begin
			mant_c = mant_c >> 8;
			exp_c = exp_c + 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nt_s5 <= (q_c > lim_wide_q) ? lim_wide_q : q_c;
			nt_s6 <= nt_s5;
			nz_s6 <= nz_c;
			nt_s7 <= nt_s6;
			sz_s7 <= sz_c;
			bits_s8 <= {exp_c, mant_c};
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int i = 0; i < DW; i++) begin
				v_s4[i] <= 1'b0;
			end
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4[0] <= v_s3;
			for (int i = 1; i < DW; i++) begin
				v_s4[i] <= v_s4[i-1];
			end
			v_s5 <= v_s4[DW-1];
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign result_valid = v_s8;
	assign new_bits = bits_s8;

	`DRU_ASSERT_IMP(a_stall_blocks_input, result_valid && !result_ready, !item_ready)
	`DRU_ASSERT_NXT(a_accept_enters, item_valid && item_ready, v_s1)
	`DRU_ASSERT_IMP(a_mant_normalised, result_valid, !new_bits[23])
	`DRU_ASSERT_IMP(a_exp_in_range, result_valid, new_bits[31:24] <= 8'd33)
	`DRU_ASSERT_NXT(a_stall_holds_div, !en && v_s4[DW-1], v_s4[DW-1])

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the difficulty retarget unit.
`default_nettype none
module tb;

	// Byte addresses of the two registers: the timespan is 40 bits wide, so both sit on 8-byte steps.
	localparam logic [3:0] ADDR_TIMESPAN = 4'd0;
	localparam logic [3:0] ADDR_LIMIT    = 4'd8;
	// The pipeline is 321 stages deep; settling waits are longer than that.
	localparam int PIPE_DEPTH = 321;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [31:0] old_bits;
	logic [63:0] elapsed_time;
	logic        result_valid;
	logic        result_ready;
	logic [31:0] new_bits;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	difficulty_retarget_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready),
		.old_bits(old_bits), .elapsed_time(elapsed_time),
		.result_valid(result_valid), .result_ready(result_ready), .new_bits(new_bits),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copies of the two registers, kept in step with every write.
	logic [39:0] cur_timespan;
	logic [31:0] cur_limit;

	// Compact words expected on the result channel, oldest first.
	logic [31:0] expected_bits_q[$];
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("TEST FAILED");
		$finish;
	end

	// Expands a compact word into its full 256-bit target.
	function automatic logic [255:0] target_of(input logic [31:0] b);
		logic [7:0]   e;
		logic [23:0]  m;
		logic [255:0] t;
		e = b[31:24];
		m = b[23:0];
		t = '0;
		if (e <= 8'd3) begin
			t = 256'(m >> (8 * (3 - e)));
		end else begin
			for (int i = 0; i < 3; i++) begin
				if (int'(e) - 3 + i < 32)
					t[(int'(e) - 3 + i) * 8 +: 8] = m[i * 8 +: 8];
			end
		end
		return t;
	endfunction

	// Re-encodes a 256-bit target as a compact word, shifting the mantissa when its top bit is set.
	function automatic logic [31:0] compact_of(input logic [255:0] t);
		int          nbytes;
		logic [31:0] mant;
		logic [31:0] e;
		nbytes = 32;
		mant = '0;
		while (nbytes > 0 && t[(nbytes - 1) * 8 +: 8] == 8'h00)
			nbytes--;
		e = nbytes;
		if (nbytes >= 3)
			mant = {8'h00, t[(nbytes - 1) * 8 +: 8], t[(nbytes - 2) * 8 +: 8],
				t[(nbytes - 3) * 8 +: 8]};
		else if (nbytes == 2)
			mant = {8'h00, t[15:8], t[7:0], 8'h00};
		else if (nbytes == 1)
			mant = {8'h00, t[7:0], 16'h0000};
		if (mant[23]) begin
			mant = mant >> 8;
			e = e + 1;
		end
		return (e << 24) | mant;
	endfunction

	// Works out the new compact target from the old one, the elapsed time and the registers.
	function automatic logic [31:0] retarget(input logic [31:0] old_word, input logic [63:0] el_raw);
		logic signed [63:0] el;
		logic signed [63:0] lo;
		logic signed [63:0] hi;
		logic [63:0]        ts;
		logic [319:0]       scaled;
		logic [319:0]       quot;
		logic [255:0]       nt;
		logic [255:0]       cap;
		ts = (cur_timespan == 40'd0) ? 64'd1 : {24'd0, cur_timespan};
		el = el_raw;
		lo = ts / 4;
		hi = ts * 4;
		if (el < lo)
			el = lo;
		if (el > hi)
			el = hi;
		scaled = 320'(target_of(old_word)) * 320'(el);
		quot = scaled / 320'(ts);
		nt = quot[255:0];
		cap = target_of(cur_limit);
		if (nt > cap)
			nt = cap;
		return compact_of(nt);
	endfunction

	// One register write: a setup phase and then an access phase, driven on falling edges.
	task automatic write_reg(input dret_pkg::reg_idx_t idx, input logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= (idx == dret_pkg::REG_TIMESPAN) ? ADDR_TIMESPAN : ADDR_LIMIT;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == dret_pkg::REG_TIMESPAN)
			cur_timespan = value[39:0];
		else
			cur_limit = value[31:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers one transaction, possibly after a random gap, and waits until it is taken.
	// Valid is only lowered when the next item is not offered straight away.
	task automatic send_item(input logic [31:0] ob, input logic [63:0] el);
		if (send_idle_pct > 0) begin
			while ($urandom_range(99) < send_idle_pct) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_valid <= 1'b1;
		old_bits <= ob;
		elapsed_time <= el;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		expected_bits_q.push_back(retarget(ob, el));
		@(negedge clk);
	endtask

	// Waits until every expected result has come back, then lets the pipeline drain.
	task automatic wait_idle();
		int guard;
		guard = 0;
		item_valid <= 1'b0;
		while (expected_bits_q.size() != 0 && guard < 2000000) begin
			@(negedge clk);
			guard++;
		end
		if (guard >= 2000000) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			repeat (PIPE_DEPTH + 20) @(negedge clk);
		end
	endtask

	// Elapsed times mostly around the timespan, with the clamp region and the extremes reached too.
	function automatic logic [63:0] pick_elapsed();
		logic [63:0] ts;
		ts = {24'd0, cur_timespan};
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return ts / 4 + 64'($urandom_range(3)) - 64'd2;
			2: return ts * 4 + 64'($urandom_range(3)) - 64'd2;
			3: return -64'($urandom_range(1000));
			4: return {1'b0, {63{1'b1}}} - 64'($urandom_range(3));
			default: return ts / 4 + (({$urandom, $urandom}) % (ts * 4 + 64'd1));
		endcase
	endfunction

	// Compact words that are mostly well formed, with odd exponents and mantissas mixed in.
	function automatic logic [31:0] pick_bits();
		logic [7:0] e;
		case ($urandom_range(7))
			0: return $urandom;
			1: e = 8'($urandom_range(3));
			2: e = 8'($urandom_range(40, 29));
			default: e = 8'($urandom_range(32, 4));
		endcase
		return {e, 24'($urandom)};
	endfunction

	// Checks each result transaction against the oldest expectation.
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_bits_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result new_bits=%h", new_bits);
			end else begin
				want = expected_bits_q.pop_front();
				if (new_bits !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("new_bits mismatch: expected %h, got %h", want, new_bits);
				end
			end
		end
	end

	// Receiver side: random stalls, or a long hold-off counted in cycles when one is asked for.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			result_ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Field extremes, each special case and the register reset values.
	task automatic test_directed();
		send_item(32'h1d00ffff, 64'd1209600);
		send_item(32'h00000000, 64'd0);
		send_item(32'hffffffff, 64'hffffffffffffffff);
		send_item(32'h03123456, 64'h8000000000000000);
		send_item(32'h02123456, 64'h7fffffffffffffff);
		send_item(32'h01123456, 64'd302400);
		send_item(32'h00ffffff, 64'd4838400);
		send_item(32'h20ffffff, 64'd4838400);
		send_item(32'h21ffffff, 64'd1);
		send_item(32'h22abcdef, 64'd2000000);
		send_item(32'h1f800000, 64'd4838399);
		send_item(32'h1e0fffff, 64'd4838401);
		send_item(32'h1c7fffff, 64'd302399);
		send_item(32'h04000080, 64'd1209601);
		wait_idle();
		// A zero timespan acts as one; a limit word of all ones expands to zero and caps every target.
		write_reg(dret_pkg::REG_TIMESPAN, 64'd0);
		write_reg(dret_pkg::REG_LIMIT, 64'h00000000ffffffff);
		send_item(32'h20ffffff, 64'd4);
		send_item(32'h21ffffff, 64'd3);
		send_item(32'h217fffff, 64'd4);
		send_item(32'h0400ffff, -64'd5);
		send_item(32'h03800000, 64'd2);
		wait_idle();
		write_reg(dret_pkg::REG_TIMESPAN, 64'hffffffffff);
		write_reg(dret_pkg::REG_LIMIT, 64'd0);
		send_item(32'h1d00ffff, 64'h7fffffffffffffff);
		send_item(32'h20ffffff, 64'd0);
		wait_idle();
	endtask

	// Random retargets under a given register setting and idling pattern.
	task automatic test_random(input logic [39:0] ts, input logic [31:0] lim, input int count,
		input int s_pct, input int r_pct);
		write_reg(dret_pkg::REG_TIMESPAN, {24'd0, ts});
		write_reg(dret_pkg::REG_LIMIT, {32'd0, lim});
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int i = 0; i < count; i++)
			send_item(pick_bits(), pick_elapsed());
		wait_idle();
	endtask

	// The receiver holds off long enough for the pipeline to fill and push back on the input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(negedge clk);
		hold_off_cycles = 800;
		for (int i = 0; i < 400; i++)
			send_item(pick_bits(), pick_elapsed());
		// The sender then pauses until the pipeline has emptied completely.
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		old_bits = '0;
		elapsed_time = '0;
		result_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 0;
		cur_timespan = dret_pkg::TIMESPAN_RESET;
		cur_limit = dret_pkg::LIMIT_RESET;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(40'd1209600, 32'h1e0fffff, 300, 13, 65);
		test_random(40'd1, 32'hffffffff, 150, 65, 13);
		test_random(40'd7, 32'h207fffff, 150, 65, 13);
		test_random(40'hffffffffff, 32'h1d00ffff, 150, 0, 0);
		test_random(40'd3600, 32'h00000000, 100, 13, 65);
		test_random(40'($urandom_range(100000, 10)), $urandom, 150, 0, 0);
		test_backpressure();

		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/dret_pkg.sv
sv/difficulty_retarget_unit.sv
tb/tb.sv
